>>> sv/histogram_binner_min_tracker_macros.svh
// Assertion macros shared by the histogram binner RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef HISTOGRAM_BINNER_MIN_TRACKER_MACROS_SVH
`define HISTOGRAM_BINNER_MIN_TRACKER_MACROS_SVH
// Same-cycle implication, checked only while out of reset.
`define HBMT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hbmt assertion failed");
// Next-cycle implication, checked only while out of reset.
`define HBMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hbmt assertion failed");
`endif

>>> sv/hbmt_pkg.sv
// Types, codes and helper functions of the histogram binner.
// No dependencies; used by the top level.
package hbmt_pkg;
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_IN    = 2'd0,
        REG_ABOVE = 2'd1,
        REG_BELOW = 2'd2
    } t_region;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOD,
        S_FIN,
        S_DONE
    } t_state;

    localparam logic [6:0] BINS_RESET = 7'd64;

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_add32 = s[31:0];
        end
    endfunction
endpackage

>>> sv/hbmt_req_if.sv
// Request channel of the histogram binner: handshake plus one input item.
// No dependencies.
interface hbmt_req_if;
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic signed [31:0]  position;
    logic signed [15:0]  weight;
    logic [6:0]          slot;
    modport source (output valid, opcode, position, weight, slot, input ready);
    modport sink   (input valid, opcode, position, weight, slot, output ready);
endinterface

>>> sv/hbmt_rsp_if.sv
// Result channel of the histogram binner: handshake plus one result item.
// No dependencies.
interface hbmt_rsp_if;
    logic                valid;
    logic                ready;
    logic [1:0]          region;
    logic [5:0]          bin_number;
    logic signed [31:0]  bin_content;
    logic signed [31:0]  minimum;
    logic [31:0]         insert_total;
    logic signed [31:0]  weight_total;
    logic signed [31:0]  above_sum;
    logic signed [31:0]  below_sum;
    modport source (output valid, region, bin_number, bin_content, minimum, insert_total,
                    weight_total, above_sum, below_sum, input ready);
    modport sink   (input valid, region, bin_number, bin_content, minimum, insert_total,
                    weight_total, above_sum, below_sum, output ready);
endinterface

>>> sv/hbmt_cfg_if.sv
// Configuration write channel: handshake plus the bins-in-use value.
// No dependencies.
interface hbmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [6:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/histogram_binner_min_tracker.sv
// Top level of the histogram binner with minimum tracking.
// Depends on hbmt_pkg, the three channel interfaces, hbmt_cell and the macro header.
//
//  channel  | dir | carries
//  i_req    | in  | opcode, position, weight, slot
//  o_rsp    | out | region, bin_number, bin_content, minimum, four totals
//  i_cfg    | in  | bins_in_use (always ready)
//
// A request is accepted only while idle. The ring of BIN_COUNT cells rotates once to count
// borders and once to update bins and rescan the minimum, and a final state settles the
// totals and registers the result. The result is held until the sink takes it, and only
// then is the next request accepted, so a stalled result holds off the input.
// Synchronous active-low reset clears all bins, totals and the control state.
module histogram_binner_min_tracker #(
    parameter int BIN_COUNT = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hbmt_req_if.sink   i_req,
    hbmt_cfg_if.sink   i_cfg,
    hbmt_rsp_if.source o_rsp
);
    import hbmt_pkg::*;
    `include "histogram_binner_min_tracker_macros.svh"

    localparam int KW = $clog2(BIN_COUNT + 1);
    localparam int SW = (KW > 7) ? KW : 7;
    localparam logic [KW-1:0] K_LAST = KW'(BIN_COUNT - 1);

    t_state r_state, n_state;
    logic [KW-1:0] r_k;
    logic [6:0] r_bins;
    logic [1:0] r_op;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_w;
    logic [6:0] r_slot;
    logic [KW-1:0] r_cnt;
    logic signed [31:0] r_b0, r_btop, r_top;
    logic signed [31:0] r_old, r_newbin, r_scanmin, r_rdbin;
    logic signed [31:0] r_min, r_wsum, r_above, r_below;
    logic [31:0] r_ins;
    logic [1:0] r_region;
    logic [5:0] r_binno;
    logic signed [31:0] r_content;

    logic shift;
    logic signed [31:0] w_border [BIN_COUNT];
    logic signed [31:0] w_bin [BIN_COUNT];
    logic signed [31:0] tail_border, tail_bin;
    logic [KW-1:0] n_used;
    logic [SW-1:0] cfg_ext;
    logic in_range_k;
    logic signed [31:0] top_border;
    logic [KW-1:0] idx;
    logic signed [31:0] hb, hbin, sat_bin, m1;
    t_region region_c;

    // Ring: each cell takes from its right neighbor, the last from the controller.
    for (genvar g = 0; g < BIN_COUNT; g++) begin : g_ring
        if (g == BIN_COUNT - 1) begin : g_tail
            hbmt_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                .i_border(tail_border), .i_bin(tail_bin),
                .o_border(w_border[g]), .o_bin(w_bin[g])
            );
        end else begin : g_mid
            hbmt_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                .i_border(w_border[g+1]), .i_bin(w_bin[g+1]),
                .o_border(w_border[g]), .o_bin(w_bin[g])
            );
        end
    end

    assign hb   = w_border[0];
    assign hbin = w_bin[0];

    always_comb begin
        cfg_ext = SW'(r_bins);
        if (cfg_ext == '0) begin
            n_used = KW'(1);
        end else if (cfg_ext > SW'(BIN_COUNT)) begin
            n_used = KW'(BIN_COUNT);
        end else begin
            n_used = KW'(cfg_ext);
        end
    end

    assign in_range_k = (r_k < n_used);
    assign idx        = (r_cnt == '0) ? '0 : r_cnt - KW'(1);
    assign top_border = (n_used == KW'(BIN_COUNT)) ? r_top : r_btop;
    assign sat_bin    = sat_add32(hbin, r_w);
    assign m1         = sat_add32(r_min, r_w);

    always_comb begin
        if (r_pos >= top_border) begin
            region_c = REG_ABOVE;
        end else if (r_pos < r_b0) begin
            region_c = REG_BELOW;
        end else begin
            region_c = REG_IN;
        end
    end

    // Data handed to the tail cell; in the second pass the head is modified on its way.
    always_comb begin
        tail_border = hb;
        tail_bin    = hbin;
        if (r_state == S_MOD) begin
            unique case (t_opcode'(r_op))
                OP_ADD: begin
                    if (region_c == REG_IN && r_k == idx) begin
                        tail_bin = sat_bin;
                    end
                end
                OP_LOAD: begin
                    if (SW'(r_k) == SW'(r_slot)) begin
                        tail_border = r_pos;
                    end
                end
                OP_CLEAR: begin
                    if (in_range_k) begin
                        tail_bin = '0;
                    end
                end
                OP_READ: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_SCAN;
            S_SCAN: if (r_k == K_LAST) n_state = S_MOD;
            S_MOD:  if (r_k == K_LAST) n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        o_rsp.valid = (r_state == S_DONE);
        shift       = (r_state == S_SCAN) || (r_state == S_MOD);
        i_cfg.ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_bins  <= BINS_RESET;
            r_min   <= '0;
            r_ins   <= '0;
            r_wsum  <= '0;
            r_above <= '0;
            r_below <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_bins <= i_cfg.data;
            end
            if (shift) begin
                r_k <= (r_k == K_LAST) ? '0 : r_k + KW'(1);
            end
            if (r_state == S_FIN) begin
                unique case (t_opcode'(r_op))
                    OP_ADD: begin
                        unique case (region_c)
                            REG_ABOVE: r_above <= sat_add32(r_above, r_w);
                            REG_BELOW: r_below <= sat_add32(r_below, r_w);
                            REG_IN: begin
                                if (r_ins != 32'hffff_ffff) begin
                                    r_ins <= r_ins + 32'd1;
                                end
                                r_wsum <= sat_add32(r_wsum, r_w);
                                if (r_old == r_min) begin
                                    r_min <= (r_scanmin < m1) ? r_scanmin : m1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    OP_CLEAR: begin
                        r_min  <= '0;
                        r_ins  <= '0;
                        r_wsum <= '0;
                    end
                    OP_LOAD: ;
                    OP_READ: ;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers of the current request.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op    <= i_req.opcode;
            r_pos   <= i_req.position;
            r_w     <= 32'(i_req.weight);
            r_slot  <= i_req.slot;
            r_cnt   <= '0;
        end
        if (r_state == S_SCAN) begin
            if (in_range_k && hb <= r_pos) begin
                r_cnt <= r_cnt + KW'(1);
            end
            if (r_k == '0) begin
                r_b0 <= hb;
            end
            if (r_k == n_used) begin
                r_btop <= hb;
            end
            r_scanmin <= 32'sh7fff_ffff;
        end
        if (r_state == S_MOD) begin
            if (r_k == idx) begin
                r_old    <= hbin;
                r_newbin <= sat_bin;
            end
            if (SW'(r_k) == SW'(r_slot)) begin
                r_rdbin <= hbin;
            end
            if (in_range_k) begin
                if (r_k == idx) begin
                    if (sat_bin < r_scanmin) r_scanmin <= sat_bin;
                end else if (hbin < r_scanmin) begin
                    r_scanmin <= hbin;
                end
            end
        end
        if (r_state == S_FIN) begin
            unique case (t_opcode'(r_op))
                OP_ADD: begin
                    r_region <= region_c;
                    if (region_c == REG_IN) begin
                        r_binno   <= 6'(idx);
                        r_content <= r_newbin;
                    end else begin
                        r_binno   <= '0;
                        r_content <= '0;
                    end
                end
                OP_LOAD: begin
                    r_region  <= REG_IN;
                    r_binno   <= '0;
                    r_content <= '0;
                    if (SW'(r_slot) == SW'(BIN_COUNT)) begin
                        r_top <= r_pos;
                    end
                end
                OP_READ: begin
                    r_region <= REG_IN;
                    r_binno  <= r_slot[5:0];
                    if (SW'(r_slot) < SW'(BIN_COUNT)) begin
                        r_content <= r_rdbin;
                    end else begin
                        r_content <= '0;
                    end
                end
                OP_CLEAR: begin
                    r_region  <= REG_IN;
                    r_binno   <= '0;
                    r_content <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.region       = r_region;
    assign o_rsp.bin_number   = r_binno;
    assign o_rsp.bin_content  = r_content;
    assign o_rsp.minimum      = r_min;
    assign o_rsp.insert_total = r_ins;
    assign o_rsp.weight_total = r_wsum;
    assign o_rsp.above_sum    = r_above;
    assign o_rsp.below_sum    = r_below;

    `HBMT_ASSERT_NEXT(a_start, i_req.valid && i_req.ready, r_state == S_SCAN && r_k == '0)
    `HBMT_ASSERT_NEXT(a_pass, r_state == S_SCAN && r_k == K_LAST, r_state == S_MOD && r_k == '0)
    `HBMT_ASSERT_NEXT(a_ret, o_rsp.valid && o_rsp.ready, r_state == S_IDLE && r_k == '0)
endmodule

>>> sv/hbmt_cell.sv
// One cell of the rotating ring: holds one border and one bin content.
// Depends on nothing; instantiated by the top level.
module hbmt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic signed [31:0] i_border,
    input  logic signed [31:0] i_bin,
    output logic signed [31:0] o_border,
    output logic signed [31:0] o_bin
);
    logic signed [31:0] r_border;
    logic signed [31:0] r_bin;

    // Borders are undefined until loaded, so only the bin has a reset.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_border <= i_border;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
        end else if (i_shift) begin
            r_bin <= i_bin;
        end
    end

    assign o_border = r_border;
    assign o_bin    = r_bin;
endmodule
